/* rtl/sld_pkg.sv */
// Shared types, constants and helper functions for the scanner line deframer.
package sld_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned AFX_IDX_W = 3;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_LEN   = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              ovf;
  } out_word_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20) || (c == 8'h85) || (c == 8'hA0);
  endfunction

  function automatic logic is_term(input logic [BYTE_W-1:0] c);
    return (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

endpackage

/* rtl/sld_frame_mem.sv */
// Frame store: single write port, single registered read port.
module sld_frame_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [sld_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [sld_pkg::BYTE_W-1:0] rdata_r
);

  logic [sld_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read, so the sequencer may wait on it.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* rtl/sld_ctrl.sv */
// Sequencer: gathers words into the frame store, then trims, strips and emits.
module sld_ctrl #(
  parameter int unsigned FRAME_DEPTH = 64,
  parameter int unsigned AFFIX_MAX   = 8,
  parameter int unsigned AW          = 6,
  parameter int unsigned CW          = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sld_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sld_pkg::BYTE_W-1:0]    in_byte,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [sld_pkg::BYTE_W-1:0]    mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [sld_pkg::BYTE_W-1:0]    mem_rdata,
  input  logic                          slot_free,
  output logic                          push,
  output sld_pkg::out_word_t            push_word
);

  typedef enum logic [3:0] {
    S_COLLECT,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_PRE_INIT,
    S_PRE_RD,
    S_PRE_CHK,
    S_SUF_INIT,
    S_SUF_RD,
    S_SUF_CHK,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  localparam logic [CW-1:0]              DEPTH_C = CW'(FRAME_DEPTH);
  localparam logic [sld_pkg::LEN_W-1:0] AFX_MAX_C = sld_pkg::LEN_W'(AFFIX_MAX);

  state_t                        state_r;
  logic [CW-1:0]                 fill_r;
  logic                          ovf_r;
  logic                          frame_ovf_r;
  logic [CW-1:0]                 start_r;
  logic [CW-1:0]                 end_r;
  logic [sld_pkg::AFX_IDX_W-1:0] idx_r;
  logic [sld_pkg::WORD_W-1:0]    prefix_bytes_r;
  logic [sld_pkg::LEN_W-1:0]     prefix_len_r;
  logic [sld_pkg::WORD_W-1:0]    suffix_bytes_r;
  logic [sld_pkg::LEN_W-1:0]     suffix_len_r;

  logic                          in_fire;
  logic                          term;
  logic [CW-1:0]                 span;
  logic [sld_pkg::LEN_W-1:0]     idx_next;
  logic [sld_pkg::LEN_W-1:0]     cfg_len;
  logic [sld_pkg::BYTE_W-1:0]    pre_pat;
  logic [sld_pkg::BYTE_W-1:0]    suf_pat;

  assign in_ready  = (state_r == S_COLLECT);
  assign in_fire   = in_valid && in_ready;
  assign term      = sld_pkg::is_term(in_byte);
  assign span      = end_r - start_r;
  assign idx_next  = {1'b0, idx_r} + sld_pkg::LEN_W'(1);
  assign cfg_len   = (cfg_wdata[sld_pkg::LEN_W-1:0] > AFX_MAX_C) ?
                     AFX_MAX_C : cfg_wdata[sld_pkg::LEN_W-1:0];
  assign pre_pat   = prefix_bytes_r[{idx_r, 3'b000} +: sld_pkg::BYTE_W];
  assign suf_pat   = suffix_bytes_r[{idx_r, 3'b000} +: sld_pkg::BYTE_W];

  assign mem_we    = in_fire && !term && (fill_r != DEPTH_C);
  assign mem_waddr = fill_r[AW-1:0];
  assign mem_wdata = in_byte;

  // The store is only read after collection has closed, so a read never
  // meets a write to the same entry.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = start_r[AW-1:0];
    unique case (state_r)
      S_HEAD_RD, S_EMIT_RD: begin
        mem_re    = (start_r != end_r);
        mem_raddr = start_r[AW-1:0];
      end
      S_TAIL_RD: begin
        mem_re    = (start_r != end_r);
        mem_raddr = AW'(end_r - CW'(1));
      end
      S_PRE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(start_r + CW'(idx_r));
      end
      S_SUF_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(end_r - CW'(suffix_len_r) + CW'(idx_r));
      end
      default: begin
        mem_re    = 1'b0;
        mem_raddr = start_r[AW-1:0];
      end
    endcase
  end

  assign push           = (state_r == S_EMIT_LD) && slot_free;
  assign push_word.data = mem_rdata;
  assign push_word.last = ((start_r + CW'(1)) == end_r);
  assign push_word.ovf  = frame_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_COLLECT;
      fill_r         <= '0;
      ovf_r          <= 1'b0;
      prefix_bytes_r <= '0;
      prefix_len_r   <= '0;
      suffix_bytes_r <= '0;
      suffix_len_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sld_pkg::REG_PREFIX_BYTES: prefix_bytes_r <= cfg_wdata;
          sld_pkg::REG_PREFIX_LEN:   prefix_len_r   <= cfg_len;
          sld_pkg::REG_SUFFIX_BYTES: suffix_bytes_r <= cfg_wdata;
          sld_pkg::REG_SUFFIX_LEN:   suffix_len_r   <= cfg_len;
          default: ;
        endcase
      end

      unique case (state_r)
        S_COLLECT: begin
          if (in_fire) begin
            if (!term) begin
              if (fill_r != DEPTH_C) begin
                fill_r <= fill_r + CW'(1);
              end else begin
                ovf_r <= 1'b1;
              end
            end else begin
              start_r     <= '0;
              end_r       <= fill_r;
              frame_ovf_r <= ovf_r;
              fill_r      <= '0;
              ovf_r       <= 1'b0;
              if (fill_r != '0) begin
                state_r <= S_HEAD_RD;
              end
            end
          end
        end
        S_HEAD_RD: begin
          state_r <= (start_r == end_r) ? S_COLLECT : S_HEAD_CHK;
        end
        S_HEAD_CHK: begin
          if (sld_pkg::is_blank(mem_rdata)) begin
            start_r <= start_r + CW'(1);
            state_r <= S_HEAD_RD;
          end else begin
            state_r <= S_TAIL_RD;
          end
        end
        S_TAIL_RD: begin
          state_r <= (start_r == end_r) ? S_COLLECT : S_TAIL_CHK;
        end
        S_TAIL_CHK: begin
          if (sld_pkg::is_blank(mem_rdata)) begin
            end_r   <= end_r - CW'(1);
            state_r <= S_TAIL_RD;
          end else begin
            state_r <= S_PRE_INIT;
          end
        end
        S_PRE_INIT: begin
          idx_r <= '0;
          if ((prefix_len_r != '0) && (span >= CW'(prefix_len_r))) begin
            state_r <= S_PRE_RD;
          end else begin
            state_r <= S_SUF_INIT;
          end
        end
        S_PRE_RD: begin
          state_r <= S_PRE_CHK;
        end
        S_PRE_CHK: begin
          // A mismatch anywhere leaves the frame untouched.
          if (mem_rdata != pre_pat) begin
            state_r <= S_SUF_INIT;
          end else if (idx_next == prefix_len_r) begin
            start_r <= start_r + CW'(prefix_len_r);
            state_r <= S_SUF_INIT;
          end else begin
            idx_r   <= idx_next[sld_pkg::AFX_IDX_W-1:0];
            state_r <= S_PRE_RD;
          end
        end
        S_SUF_INIT: begin
          idx_r <= '0;
          if ((suffix_len_r != '0) && (span >= CW'(suffix_len_r))) begin
            state_r <= S_SUF_RD;
          end else begin
            state_r <= S_EMIT_RD;
          end
        end
        S_SUF_RD: begin
          state_r <= S_SUF_CHK;
        end
        S_SUF_CHK: begin
          if (mem_rdata != suf_pat) begin
            state_r <= S_EMIT_RD;
          end else if (idx_next == suffix_len_r) begin
            end_r   <= end_r - CW'(suffix_len_r);
            state_r <= S_EMIT_RD;
          end else begin
            idx_r   <= idx_next[sld_pkg::AFX_IDX_W-1:0];
            state_r <= S_SUF_RD;
          end
        end
        S_EMIT_RD: begin
          state_r <= (start_r == end_r) ? S_COLLECT : S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (slot_free) begin
            start_r <= start_r + CW'(1);
            state_r <= S_EMIT_RD;
          end
        end
        default: begin
          state_r <= S_COLLECT;
        end
      endcase
    end
  end

endmodule

/* rtl/sld_out_reg.sv */
// Output register that holds one result word until the receiver takes it.
module sld_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  sld_pkg::out_word_t         push_word,
  output logic                       slot_free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sld_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_frame_last,
  output logic                       out_overflowed
);

  logic               valid_r;
  sld_pkg::out_word_t word_r;

  assign slot_free      = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_byte       = word_r.data;
  assign out_frame_last = word_r.last;
  assign out_overflowed = word_r.ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word_r <= push_word;
    end
  end

endmodule

/* rtl/scanner_line_deframer_core.sv */
// Top level of the scanner line deframer: frame store, sequencer and output register.
//
// Bytes from the scanner enter on in_valid/in_ready, one byte per cycle while
// a frame is being gathered. CR or LF closes the frame; in_ready then stays
// low while the sequencer walks the frame store, reading one entry at a time
// through the memory's single registered read port: one read per leading or
// trailing blank, per compared prefix or suffix byte and per byte emitted.
// An empty frame leaves in_ready high.
// Result words leave on out_valid/out_ready from an output register, with
// out_frame_last on the final byte and out_overflowed if bytes beyond
// FRAME_DEPTH were dropped. When the receiver stalls, emission simply waits
// on the output register; no byte is lost. After the last byte of a frame
// enters the output register, input acceptance resumes via S_EMIT_RD.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// Synchronous reset clears the fill count, the overflow mark and all
// configuration registers; the frame store needs no clearing pass.
module scanner_line_deframer_core #(
  parameter int unsigned FRAME_DEPTH = 64,
  parameter int unsigned AFFIX_MAX   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sld_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sld_pkg::BYTE_W-1:0]    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sld_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_frame_last,
  output logic                          out_overflowed
);

  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [sld_pkg::BYTE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [sld_pkg::BYTE_W-1:0] mem_rdata;
  logic                       slot_free;
  logic                       push;
  sld_pkg::out_word_t         push_word;

  sld_frame_mem #(
    .DEPTH (FRAME_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  sld_ctrl #(
    .FRAME_DEPTH (FRAME_DEPTH),
    .AFFIX_MAX   (AFFIX_MAX),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .slot_free (slot_free),
    .push      (push),
    .push_word (push_word)
  );

  sld_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_word      (push_word),
    .slot_free      (slot_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_frame_last (out_frame_last),
    .out_overflowed (out_overflowed)
  );

  // The store is never written and read in the same cycle.
  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("frame store written and read in the same cycle");

  // No read of the store while bytes are still being gathered.
  a_no_read_collect: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mem_re)
    else $error("frame store read while collecting");

  // A new result word never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !(out_valid && !out_ready))
    else $error("output word overwritten while stalled");

endmodule

/* sim/scanner_line_deframer_core_tb.sv */
// Self-checking testbench for scanner_line_deframer_core: directed and random byte streams.
module scanner_line_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_DEPTH  = 64;
  localparam int AFFIX_MAX    = 8;
  localparam int CLK_HALF     = 2;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS  = 62;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {BY_MODEL, EXP_NONE, EXP_ONE} row_chk_t;

  typedef struct packed {
    row_kind_t                     kind;
    row_chk_t                      chk;
    logic [sld_pkg::CFG_IDX_W-1:0] idx;
    logic [sld_pkg::WORD_W-1:0]    value;
    logic [sld_pkg::BYTE_W-1:0]    exp_byte;
  } row_t;

  localparam row_t SCRIPT [29] = '{
    '{ROW_BYTE, BY_MODEL, '0, 64'h00, 8'h00},
    '{ROW_BYTE, EXP_ONE,  '0, {56'd0, sld_pkg::CHAR_CR}, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'hFF, 8'h00},
    '{ROW_BYTE, EXP_ONE,  '0, {56'd0, sld_pkg::CHAR_LF}, 8'hFF},
    '{ROW_BYTE, BY_MODEL, '0, 64'h78, 8'h00},
    '{ROW_BYTE, EXP_ONE,  '0, {56'd0, sld_pkg::CHAR_CR}, 8'h78},
    '{ROW_BYTE, EXP_NONE, '0, {56'd0, sld_pkg::CHAR_LF}, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h20, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h85, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h61, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'hA0, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h62, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h09, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h0B, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h0C, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, {56'd0, sld_pkg::CHAR_CR}, 8'h00},
    '{ROW_CFG,  BY_MODEL, sld_pkg::REG_PREFIX_BYTES, 64'h4241, 8'h00},
    '{ROW_CFG,  BY_MODEL, sld_pkg::REG_PREFIX_LEN,   64'd2, 8'h00},
    '{ROW_CFG,  BY_MODEL, sld_pkg::REG_SUFFIX_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00},
    '{ROW_CFG,  BY_MODEL, sld_pkg::REG_SUFFIX_LEN,   64'd15, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h41, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h42, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h43, 8'h00},
    '{ROW_BYTE, EXP_ONE,  '0, {56'd0, sld_pkg::CHAR_CR}, 8'h43},
    '{ROW_BYTE, BY_MODEL, '0, 64'h41, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h42, 8'h00},
    '{ROW_BYTE, EXP_NONE, '0, {56'd0, sld_pkg::CHAR_LF}, 8'h00},
    '{ROW_BYTE, BY_MODEL, '0, 64'h41, 8'h00},
    '{ROW_BYTE, EXP_ONE,  '0, {56'd0, sld_pkg::CHAR_CR}, 8'h41}
  };

  localparam logic [sld_pkg::BYTE_W-1:0] BLANK_SET [6] =
    '{8'h09, 8'h0B, 8'h0C, 8'h20, 8'h85, 8'hA0};

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [sld_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sld_pkg::WORD_W-1:0]    cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic [sld_pkg::BYTE_W-1:0]    in_byte;
  logic                          out_valid;
  logic                          out_ready;
  logic [sld_pkg::BYTE_W-1:0]    out_byte;
  logic                          out_frame_last;
  logic                          out_overflowed;

  // Predictor state: configuration copy and the frame being gathered.
  logic [sld_pkg::WORD_W-1:0] pfx_bytes;
  logic [sld_pkg::LEN_W-1:0]  pfx_len;
  logic [sld_pkg::WORD_W-1:0] sfx_bytes;
  logic [sld_pkg::LEN_W-1:0]  sfx_len;
  logic [sld_pkg::BYTE_W-1:0] held_q[$];
  logic                       held_ovf;
  sld_pkg::out_word_t         frame_words[$];
  sld_pkg::out_word_t         pending_words[$];
  sld_pkg::out_word_t         want;

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int frames_closed;
  int words_checked;
  int ovf_frames;
  int mismatches;

  scanner_line_deframer_core #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .AFFIX_MAX  (AFFIX_MAX)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_frame_last(out_frame_last),
    .out_overflowed(out_overflowed)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  function automatic bit blank_char(input logic [sld_pkg::BYTE_W-1:0] c);
    unique case (c)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int affix_len(input logic [sld_pkg::LEN_W-1:0] len);
    return (int'(len) > AFFIX_MAX) ? AFFIX_MAX : int'(len);
  endfunction

  // Trim, strip the affixes and turn what is left into result words.
  function automatic void clean_frame();
    int lo;
    int hi;
    int plen;
    int slen;
    bit hit;
    lo = 0;
    hi = held_q.size();
    while (lo < hi && blank_char(held_q[lo])) lo++;
    while (hi > lo && blank_char(held_q[hi-1])) hi--;
    plen = affix_len(pfx_len);
    if (plen != 0 && hi - lo >= plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (held_q[lo+i] != pfx_bytes[i*8 +: 8]) hit = 1'b0;
      if (hit) lo += plen;
    end
    slen = affix_len(sfx_len);
    if (slen != 0 && hi - lo >= slen) begin
      hit = 1'b1;
      for (int i = 0; i < slen; i++)
        if (held_q[hi-slen+i] != sfx_bytes[i*8 +: 8]) hit = 1'b0;
      if (hit) hi -= slen;
    end
    for (int k = lo; k < hi; k++)
      frame_words.push_back(sld_pkg::out_word_t'{data: held_q[k], last: (k == hi - 1),
                                                 ovf: held_ovf});
    held_q.delete();
    held_ovf = 1'b0;
  endfunction

  function automatic void deframe_byte(input logic [sld_pkg::BYTE_W-1:0] b);
    frame_words.delete();
    if (b == sld_pkg::CHAR_CR || b == sld_pkg::CHAR_LF) begin
      frames_closed++;
      clean_frame();
    end else if (held_q.size() < FRAME_DEPTH) begin
      held_q.push_back(b);
    end else begin
      held_ovf = 1'b1;
    end
  endfunction

  function automatic logic [sld_pkg::BYTE_W-1:0] body_byte();
    logic [sld_pkg::BYTE_W-1:0] b;
    do b = 8'($urandom_range(255)); while (b == sld_pkg::CHAR_CR || b == sld_pkg::CHAR_LF);
    return b;
  endfunction

  function automatic logic [sld_pkg::WORD_W-1:0] printable_pattern();
    logic [sld_pkg::WORD_W-1:0] v;
    for (int i = 0; i < 8; i++) v[i*8 +: 8] = 8'($urandom_range(8'h7E, 8'h21));
    return v;
  endfunction

  task automatic push_byte(input logic [sld_pkg::BYTE_W-1:0] b,
                           input row_chk_t chk = BY_MODEL,
                           input logic [sld_pkg::BYTE_W-1:0] typed_byte = 8'h00);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    deframe_byte(b);
    unique case (chk)
      EXP_ONE: pending_words.push_back(sld_pkg::out_word_t'{data: typed_byte, last: 1'b1,
                                                            ovf: 1'b0});
      EXP_NONE: ;
      default: foreach (frame_words[i]) pending_words.push_back(frame_words[i]);
    endcase
  endtask

  // An all-blank frame still keeps the sequencer busy after the last word,
  // so a fixed drain follows the empty queue.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sld_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sld_pkg::WORD_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    unique case (idx)
      sld_pkg::REG_PREFIX_BYTES: pfx_bytes = val;
      sld_pkg::REG_PREFIX_LEN:   pfx_len   = val[sld_pkg::LEN_W-1:0];
      sld_pkg::REG_SUFFIX_BYTES: sfx_bytes = val;
      sld_pkg::REG_SUFFIX_LEN:   sfx_len   = val[sld_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One barcode line: blanks, optional affixes around a body, blanks and a
  // terminator; some lines are corrupted and some are plain noise.
  task automatic send_frame(input bit big);
    logic [sld_pkg::BYTE_W-1:0] line[$];
    int n;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(6, 1);
      repeat (n) line.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2)) line.push_back(BLANK_SET[$urandom_range(5)]);
      if ($urandom_range(1))
        for (int i = 0; i < affix_len(pfx_len); i++) line.push_back(pfx_bytes[i*8 +: 8]);
      n = big ? $urandom_range(70, 56) : $urandom_range(8);
      repeat (n) line.push_back(body_byte());
      if ($urandom_range(1))
        for (int i = 0; i < affix_len(sfx_len); i++) line.push_back(sfx_bytes[i*8 +: 8]);
      if (line.size() > 0 && $urandom_range(4) == 0)
        line[$urandom_range(line.size() - 1)] = body_byte();
      repeat ($urandom_range(2)) line.push_back(BLANK_SET[$urandom_range(5)]);
      line.push_back($urandom_range(1) ? sld_pkg::CHAR_CR : sld_pkg::CHAR_LF);
      if ($urandom_range(3) == 0) line.push_back(sld_pkg::CHAR_LF);
    end
    foreach (line[i]) push_byte(line[i]);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: byte %02h last %0b ovf %0b", $time,
                 out_byte, out_frame_last, out_overflowed);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (want.last && want.ovf) ovf_frames++;
        if (out_byte !== want.data) begin
          mismatches++;
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
        end
        if (out_frame_last !== want.last) begin
          mismatches++;
          $display("%0t: out_frame_last expected %0b actual %0b", $time,
                   want.last, out_frame_last);
        end
        if (out_overflowed !== want.ovf) begin
          mismatches++;
          $display("%0t: out_overflowed expected %0b actual %0b", $time,
                   want.ovf, out_overflowed);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int base;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_byte        = '0;
    pfx_bytes      = '0;
    pfx_len        = '0;
    sfx_bytes      = '0;
    sfx_len        = '0;
    held_ovf       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    frames_closed  = 0;
    words_checked  = 0;
    ovf_frames     = 0;
    mismatches     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[r]) begin
      if (SCRIPT[r].kind == ROW_CFG) begin
        settle();
        write_reg(SCRIPT[r].idx, SCRIPT[r].value);
      end else begin
        push_byte(SCRIPT[r].value[sld_pkg::BYTE_W-1:0], SCRIPT[r].chk, SCRIPT[r].exp_byte);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      unique case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_reg(sld_pkg::REG_PREFIX_BYTES, printable_pattern());
          write_reg(sld_pkg::REG_PREFIX_LEN, 64'd8);
          write_reg(sld_pkg::REG_SUFFIX_BYTES, printable_pattern());
          write_reg(sld_pkg::REG_SUFFIX_LEN, 64'd3);
        end
        1: begin
          send_idle_pct = 72; recv_stall_pct = 0;
          write_reg(sld_pkg::REG_PREFIX_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(sld_pkg::REG_PREFIX_LEN, 64'd15);
          write_reg(sld_pkg::REG_SUFFIX_BYTES, 64'h0);
          write_reg(sld_pkg::REG_SUFFIX_LEN, 64'd8);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 72;
          write_reg(sld_pkg::REG_PREFIX_BYTES, printable_pattern());
          write_reg(sld_pkg::REG_PREFIX_LEN, 64'd1);
          write_reg(sld_pkg::REG_SUFFIX_BYTES, printable_pattern());
          write_reg(sld_pkg::REG_SUFFIX_LEN, 64'd0);
        end
        default: begin
          send_idle_pct = 14; recv_stall_pct = 14;
          write_reg(sld_pkg::REG_PREFIX_BYTES, printable_pattern());
          write_reg(sld_pkg::REG_PREFIX_LEN, 64'($urandom_range(15)));
          write_reg(sld_pkg::REG_SUFFIX_BYTES, printable_pattern());
          write_reg(sld_pkg::REG_SUFFIX_LEN, 64'($urandom_range(15)));
        end
      endcase
      base = items_sent;
      // Odd phases open with a long line that may overrun the store.
      if (ph % 2 == 1) send_frame(1'b1);
      while (items_sent < base + PHASE_ITEMS) send_frame(1'b0);
    end

    settle();
    $display("Run covered %0d input bytes in %0d lines over four configurations.",
             items_sent, frames_closed);
    $display("Checked %0d cleaned bytes; %0d lines carried the overflow mark.",
             words_checked, ovf_frames);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
